FILE: hw/rtl/rhsv_pkg.sv
// shared types and constants of the 8-bit rgb to hsv converter
package rhsv_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned NumWidth  = 2 * ChanWidth;
   // one divider cell per quotient bit
   localparam int unsigned CellCount = ChanWidth;

   // hue offsets of the three sectors on the 0..255 circle
   localparam logic [ChanWidth-1:0] HueBaseRed   = 8'd0;
   localparam logic [ChanWidth-1:0] HueBaseGreen = 8'd85;
   localparam logic [ChanWidth-1:0] HueBaseBlue  = 8'd171;

   // transaction state after max/min sorting
   typedef struct packed {
      logic [ChanWidth-1:0] val;
      logic [ChanWidth-1:0] mn;
      logic [ChanWidth-1:0] mag;
      logic                 neg;
      logic [ChanWidth-1:0] base;
   } sort_type;

   // transaction state handed along the divider cells
   typedef struct packed {
      logic [NumWidth-1:0]  sat_rem;
      logic [NumWidth-1:0]  sat_ds;
      logic [ChanWidth-1:0] sat_q;
      logic [NumWidth-1:0]  hue_rem;
      logic [NumWidth-1:0]  hue_ds;
      logic [ChanWidth-1:0] hue_q;
      logic [ChanWidth-1:0] val;
      logic                 hue_neg;
      logic [ChanWidth-1:0] hue_base;
      logic                 black;
      logic                 grey;
   } div_type;

endpackage

FILE: hw/rtl/rhsv_front.sv
// front end: channel sorting, delta and scaled numerators
module rhsv_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [rhsv_pkg::ChanWidth-1:0]  red,
   input  logic [rhsv_pkg::ChanWidth-1:0]  green,
   input  logic [rhsv_pkg::ChanWidth-1:0]  blue,
   output logic                            out_valid,
   input  logic                            out_ready,
   output rhsv_pkg::div_type               out_data
);

   logic                  s1_valid_ff;
   rhsv_pkg::sort_type    s1_data_ff;
   rhsv_pkg::sort_type    s1_data_in;
   logic                  s1_ready;
   logic                  s2_valid_ff;
   rhsv_pkg::div_type     s2_data_ff;
   rhsv_pkg::div_type     s2_data_in;
   logic                  s2_ready;
   logic                  red_max;
   logic                  green_max;
   logic [rhsv_pkg::ChanWidth-1:0] min_rg;
   logic [rhsv_pkg::ChanWidth-1:0] sub_a;
   logic [rhsv_pkg::ChanWidth-1:0] sub_b;
   logic [rhsv_pkg::ChanWidth-1:0] delta;
   logic [rhsv_pkg::NumWidth-1:0]  mag_w;
   logic [rhsv_pkg::NumWidth-1:0]  delta_w;

   // stage 1: largest channel, smallest channel and hue difference
   always_comb begin
      red_max   = (red >= green) && (red >= blue);
      green_max = !red_max && (green >= blue);
      min_rg    = (red < green) ? red : green;
      s1_data_in.mn = (min_rg < blue) ? min_rg : blue;
      if (red_max) begin
         s1_data_in.val  = red;
         s1_data_in.base = rhsv_pkg::HueBaseRed;
         sub_a = green;
         sub_b = blue;
      end else if (green_max) begin
         s1_data_in.val  = green;
         s1_data_in.base = rhsv_pkg::HueBaseGreen;
         sub_a = blue;
         sub_b = red;
      end else begin
         s1_data_in.val  = blue;
         s1_data_in.base = rhsv_pkg::HueBaseBlue;
         sub_a = red;
         sub_b = green;
      end
      s1_data_in.neg = sub_a < sub_b;
      s1_data_in.mag = s1_data_in.neg ? (sub_b - sub_a) : (sub_a - sub_b);
   end

   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_ready && in_valid) begin
         s1_data_ff <= s1_data_in;
      end
   end

   // stage 2: delta*255 and |diff|*43, divisors aligned to the top quotient bit
   always_comb begin
      delta   = s1_data_ff.val - s1_data_ff.mn;
      delta_w = {{rhsv_pkg::ChanWidth{1'b0}}, delta};
      mag_w   = {{rhsv_pkg::ChanWidth{1'b0}}, s1_data_ff.mag};
      s2_data_in.sat_rem  = (delta_w << 8) - delta_w;
      s2_data_in.sat_ds   = {1'b0, s1_data_ff.val, 7'b0};
      s2_data_in.sat_q    = '0;
      s2_data_in.hue_rem  = (mag_w << 5) + (mag_w << 3) + (mag_w << 1) + mag_w;
      s2_data_in.hue_ds   = {1'b0, delta, 7'b0};
      s2_data_in.hue_q    = '0;
      s2_data_in.val      = s1_data_ff.val;
      s2_data_in.hue_neg  = s1_data_ff.neg;
      s2_data_in.hue_base = s1_data_ff.base;
      s2_data_in.black    = s1_data_ff.val == '0;
      s2_data_in.grey     = delta == '0;
   end

   assign s2_ready = !s2_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

FILE: hw/rtl/rhsv_div_cell.sv
// one restoring division cell: one quotient bit of each divide
module rhsv_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rhsv_pkg::div_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rhsv_pkg::div_type   out_data
);

   logic                 valid_ff;
   rhsv_pkg::div_type    data_ff;
   rhsv_pkg::div_type    data_in;
   logic                 sat_bit;
   logic                 hue_bit;

   always_comb begin
      data_in = in_data;
      sat_bit = in_data.sat_rem >= in_data.sat_ds;
      hue_bit = in_data.hue_rem >= in_data.hue_ds;
      if (sat_bit) begin
         data_in.sat_rem = in_data.sat_rem - in_data.sat_ds;
      end
      if (hue_bit) begin
         data_in.hue_rem = in_data.hue_rem - in_data.hue_ds;
      end
      data_in.sat_q  = {in_data.sat_q[rhsv_pkg::ChanWidth-2:0], sat_bit};
      data_in.hue_q  = {in_data.hue_q[rhsv_pkg::ChanWidth-2:0], hue_bit};
      // next cell works on the next lower quotient bit
      data_in.sat_ds = in_data.sat_ds >> 1;
      data_in.hue_ds = in_data.hue_ds >> 1;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hw/rtl/rhsv_back.sv
// back end: hue sign and sector offset, special cases, output register
module rhsv_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  rhsv_pkg::div_type               in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [rhsv_pkg::ChanWidth-1:0]  hue,
   output logic [rhsv_pkg::ChanWidth-1:0]  sat,
   output logic [rhsv_pkg::ChanWidth-1:0]  val
);

   logic                           valid_ff;
   logic [rhsv_pkg::ChanWidth-1:0] hue_ff;
   logic [rhsv_pkg::ChanWidth-1:0] hue_in;
   logic [rhsv_pkg::ChanWidth-1:0] sat_ff;
   logic [rhsv_pkg::ChanWidth-1:0] sat_in;
   logic [rhsv_pkg::ChanWidth-1:0] val_ff;
   logic [rhsv_pkg::ChanWidth-1:0] hue_ofs;

   always_comb begin
      // truncation toward zero: negate the magnitude quotient, wrap mod 256
      hue_ofs = in_data.hue_neg ? (~in_data.hue_q + 8'd1) : in_data.hue_q;
      hue_in  = in_data.grey ? '0 : (in_data.hue_base + hue_ofs);
      sat_in  = in_data.black ? '0 : in_data.sat_q;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= in_data.val;
      end
   end

   assign out_valid = valid_ff;
   assign hue       = hue_ff;
   assign sat       = sat_ff;
   assign val       = val_ff;

endmodule

FILE: hw/rtl/rgb_to_hsv_8bit_core.sv
// top level of the 8-bit rgb to hsv converter
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_red_in, req_green_in, req_blue_in
// rsp      out        rsp_valid / rsp_ready  rsp_hue_out, rsp_sat_out, rsp_val_out
//
// one pixel per clock sustained while rsp_ready stays high; req reaches rsp through
// two front stages, eight divider cells and one output register
// every stage is an elastic register, so bubbles are squeezed out under backpressure
// rsp_ready low stalls only the stages that are full; req_ready falls when all are
// synchronous active-high reset empties the pipeline, payload registers keep their data
module rgb_to_hsv_8bit_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_hue_out,
   output logic [7:0] rsp_sat_out,
   output logic [7:0] rsp_val_out
);

   // links between the front end, the cells and the back end:
   // index 0 is the front end output, index CellCount the last cell output
   logic              link_valid [rhsv_pkg::CellCount+1];
   logic              link_ready [rhsv_pkg::CellCount+1];
   rhsv_pkg::div_type link_data  [rhsv_pkg::CellCount+1];

   // sorting, delta and numerator scaling
   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // row of division cells, msb of both quotients first
   for (genvar i = 0; i < rhsv_pkg::CellCount; i++) begin : g_cell
      rhsv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // sector offset, sign, black and grey pixels
   rhsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[rhsv_pkg::CellCount]),
      .in_ready  (link_ready[rhsv_pkg::CellCount]),
      .in_data   (link_data[rhsv_pkg::CellCount]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .hue       (rsp_hue_out),
      .sat       (rsp_sat_out),
      .val       (rsp_val_out)
   );

endmodule

FILE: hw/rtl/rhsv_checker.sv
// port-level checks of the converter and their binding to the top level
module rhsv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_hue_out,
   input logic [7:0] rsp_sat_out,
   input logic [7:0] rsp_val_out
);

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue_out)
         && $stable(rsp_sat_out) && $stable(rsp_val_out))
      else $error("stalled rsp transaction changed");

   // black pixel has no saturation and no hue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_val_out == 8'd0 |-> rsp_sat_out == 8'd0 && rsp_hue_out == 8'd0)
      else $error("black pixel with nonzero hue or saturation");

   // zero saturation only for grey pixels, which have zero hue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sat_out == 8'd0 |-> rsp_hue_out == 8'd0)
      else $error("unsaturated pixel with nonzero hue");

   // req_ready low while no result is valid must be followed by a valid result
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_ready |=> rsp_valid)
      else $error("req_ready low while pipeline not full");

endmodule

bind rgb_to_hsv_8bit_core rhsv_checker u_rhsv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_hue_out (rsp_hue_out),
   .rsp_sat_out (rsp_sat_out),
   .rsp_val_out (rsp_val_out)
);
